// ===== sv/mstt_pkg.sv =====
// shared types, codes and constants of the software timer table
`default_nettype none

package mstt_pkg;

	localparam int REQ_W     = 2;
	localparam int OWNER_W   = 8;
	localparam int EVENT_W   = 8;
	localparam int WAIT_W    = 31;
	localparam int NOW_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int REMOVED_W = 5;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int TICK_BITS_DEF  = 32;

	localparam logic [WAIT_W-1:0]    NO_WAIT     = 31'h7fffffff;
	localparam logic [REMOVED_W-1:0] REMOVED_MAX = 5'd31;

	typedef enum logic [REQ_W-1:0] {
		REQ_START      = 2'd0,
		REQ_STOP_OWNER = 2'd1,
		REQ_STOP_EVENT = 2'd2,
		REQ_TICK       = 2'd3
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_START_OK = 2'd0,
		ST_FULL     = 2'd1,
		ST_EXPIRED  = 2'd2,
		ST_DONE     = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic emit_summary;
	} ctl_cmd_t;

	typedef struct packed {
		logic advance;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/mstt_req_if.sv =====
// request channel of the software timer table
`default_nettype none

interface mstt_req_if;
	logic                           valid;
	logic                           ready;
	logic [mstt_pkg::REQ_W-1:0]     req_type;
	logic [mstt_pkg::OWNER_W-1:0]   owner_id;
	logic [mstt_pkg::EVENT_W-1:0]   event_kind;
	logic [mstt_pkg::WAIT_W-1:0]    wait_ticks;
	logic [mstt_pkg::NOW_W-1:0]     now_tick;

	modport source (output valid, output req_type, output owner_id, output event_kind,
		output wait_ticks, output now_tick, input ready);
	modport sink (input valid, input req_type, input owner_id, input event_kind,
		input wait_ticks, input now_tick, output ready);
endinterface

`default_nettype wire

// ===== sv/mstt_rsp_if.sv =====
// result channel of the software timer table
`default_nettype none

interface mstt_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [mstt_pkg::STATUS_W-1:0]    status;
	logic [mstt_pkg::OWNER_W-1:0]     expired_owner;
	logic [mstt_pkg::EVENT_W-1:0]     expired_event;
	logic [mstt_pkg::REMOVED_W-1:0]   removed_count;
	logic [mstt_pkg::WAIT_W-1:0]      next_wait;
	logic                             any_pending;
	logic                             last;

	modport source (output valid, output status, output expired_owner, output expired_event,
		output removed_count, output next_wait, output any_pending, output last, input ready);
	modport sink (input valid, input status, input expired_owner, input expired_event,
		input removed_count, input next_wait, input any_pending, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/mstt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module mstt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/mstt_ctrl.sv =====
// controller: sequences capture, slot scan and summary of each request
`default_nettype none

module mstt_ctrl #(
	parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire mstt_pkg::dp_stat_t stat,
	output      mstt_pkg::ctl_cmd_t cmd,
	output      logic [IDX_W-1:0]   rd_idx
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DRAIN,
		SUMMARY
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;

	always_comb begin
		in_ready         = (state_q == IDLE);
		cmd.capture      = in_valid && (state_q == IDLE);
		cmd.rd_en        = (state_q == SCAN) && stat.advance;
		cmd.emit_summary = (state_q == SUMMARY) && stat.out_free;
		rd_idx           = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						idx_q   <= LAST_IDX;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (stat.advance) begin
						if (idx_q == '0) begin
							state_q <= DRAIN;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				DRAIN: begin
					if (stat.advance) begin
						state_q <= SUMMARY;
					end
				end
				SUMMARY: begin
					if (stat.out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/mstt_dp.sv =====
// datapath: slot storage, live bits, slot evaluation, summary and result register
`default_nettype none

module mstt_dp #(
	parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
	parameter int TICK_BITS  = mstt_pkg::TICK_BITS_DEF,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mstt_pkg::ctl_cmd_t              cmd,
	input  wire logic [IDX_W-1:0]                rd_idx,
	output      mstt_pkg::dp_stat_t              stat,
	input  wire logic [mstt_pkg::REQ_W-1:0]      req_type,
	input  wire logic [mstt_pkg::OWNER_W-1:0]    owner_id,
	input  wire logic [mstt_pkg::EVENT_W-1:0]    event_kind,
	input  wire logic [mstt_pkg::WAIT_W-1:0]     wait_ticks,
	input  wire logic [mstt_pkg::NOW_W-1:0]      now_tick,
	mstt_rsp_if.source                           rsp
);

	localparam int OWN_W  = mstt_pkg::OWNER_W;
	localparam int EV_W   = mstt_pkg::EVENT_W;
	localparam int WT_W   = mstt_pkg::WAIT_W;
	localparam int NB     = (TICK_BITS < mstt_pkg::NOW_W) ? TICK_BITS : mstt_pkg::NOW_W;
	localparam int CMP_W  = (TICK_BITS > WT_W) ? TICK_BITS : WT_W;
	localparam int RAM_W  = OWN_W + EV_W + WT_W + TICK_BITS;

	// request registers
	logic [mstt_pkg::REQ_W-1:0]     req_q;
	logic [OWN_W-1:0]               own_q;
	logic [EV_W-1:0]                ev_q;
	logic [TICK_BITS-1:0]           now_q;
	logic                           full_q;
	logic [WT_W-1:0]                best_q;
	logic                           pend_q;
	logic [mstt_pkg::REMOVED_W-1:0] removed_q;

	logic [SLOT_COUNT-1:0]          live_q;
	logic                           rd_valid_s1;
	logic [IDX_W-1:0]               rd_idx_s1;

	logic                           out_valid_q;
	mstt_pkg::status_t              out_status_q;
	logic [OWN_W-1:0]               out_owner_q;
	logic [EV_W-1:0]                out_event_q;
	logic [mstt_pkg::REMOVED_W-1:0] out_removed_q;
	logic [WT_W-1:0]                out_wait_q;
	logic                           out_pend_q;
	logic                           out_last_q;

	logic [TICK_BITS-1:0]           now_ext;
	logic                           free_found;
	logic [IDX_W-1:0]               free_idx;
	logic                           ram_we;
	logic [RAM_W-1:0]               ram_wdata;
	logic [RAM_W-1:0]               ram_rdata;

	logic [OWN_W-1:0]               r_own;
	logic [EV_W-1:0]                r_ev;
	logic [WT_W-1:0]                r_ivl;
	logic [TICK_BITS-1:0]           r_start;
	logic [TICK_BITS-1:0]           elapsed;
	logic [CMP_W-1:0]               el_c;
	logic                           expired;
	logic [WT_W-1:0]                left;
	logic                           slot_live;
	logic                           is_stop;
	logic                           is_tick;
	logic                           remove;
	logic                           keep;
	logic                           out_free;
	logic                           advance;
	logic                           step;
	logic                           emit_exp;

	always_comb begin
		now_ext         = '0;
		now_ext[NB-1:0] = now_tick[NB-1:0];
	end

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign ram_we    = cmd.capture && (req_type == mstt_pkg::REQ_START) && free_found;
	assign ram_wdata = {owner_id, event_kind, wait_ticks, now_ext};

	mstt_ram #(
		.WIDTH (RAM_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// slot evaluation
	always_comb begin
		r_start   = ram_rdata[TICK_BITS-1:0];
		r_ivl     = ram_rdata[TICK_BITS +: WT_W];
		r_ev      = ram_rdata[TICK_BITS + WT_W +: EV_W];
		r_own     = ram_rdata[TICK_BITS + WT_W + EV_W +: OWN_W];
		elapsed   = now_q - r_start;
		el_c      = CMP_W'(elapsed);
		expired   = el_c >= CMP_W'(r_ivl);
		left      = expired ? '0 : (r_ivl - el_c[WT_W-1:0]);
		slot_live = live_q[rd_idx_s1];
		is_stop   = (req_q == mstt_pkg::REQ_STOP_OWNER) || (req_q == mstt_pkg::REQ_STOP_EVENT);
		is_tick   = (req_q == mstt_pkg::REQ_TICK);
		remove    = slot_live && ((is_stop && (r_own == own_q) &&
			((req_q == mstt_pkg::REQ_STOP_OWNER) || (r_ev == ev_q))) || (is_tick && expired));
		keep      = slot_live && !remove;
		out_free  = !out_valid_q || rsp.ready;
		advance   = !(rd_valid_s1 && is_tick && remove && !out_free);
		step      = rd_valid_s1 && advance;
		emit_exp  = step && is_tick && remove;
	end

	assign stat.advance  = advance;
	assign stat.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				live_q[free_idx] <= 1'b1;
			end
			if (step && remove) begin
				live_q[rd_idx_s1] <= 1'b0;
			end
			if (advance) begin
				rd_valid_s1 <= cmd.rd_en;
			end
			if (emit_exp || cmd.emit_summary) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req_type;
			own_q     <= owner_id;
			ev_q      <= event_kind;
			now_q     <= now_ext;
			full_q    <= (req_type == mstt_pkg::REQ_START) && !free_found;
			best_q    <= mstt_pkg::NO_WAIT;
			pend_q    <= 1'b0;
			removed_q <= '0;
		end else if (step) begin
			if (keep) begin
				pend_q <= 1'b1;
				if (left < best_q) begin
					best_q <= left;
				end
			end
			if (is_stop && remove && (removed_q != mstt_pkg::REMOVED_MAX)) begin
				removed_q <= removed_q + 1'b1;
			end
		end
		if (advance && cmd.rd_en) begin
			rd_idx_s1 <= rd_idx;
		end
		if (emit_exp) begin
			out_status_q  <= mstt_pkg::ST_EXPIRED;
			out_owner_q   <= r_own;
			out_event_q   <= r_ev;
			out_removed_q <= '0;
			out_wait_q    <= '0;
			out_pend_q    <= 1'b0;
			out_last_q    <= 1'b0;
		end else if (cmd.emit_summary) begin
			if (req_q == mstt_pkg::REQ_START) begin
				out_status_q <= full_q ? mstt_pkg::ST_FULL : mstt_pkg::ST_START_OK;
			end else begin
				out_status_q <= mstt_pkg::ST_DONE;
			end
			out_owner_q   <= '0;
			out_event_q   <= '0;
			out_removed_q <= removed_q;
			out_wait_q    <= best_q;
			out_pend_q    <= pend_q;
			out_last_q    <= 1'b1;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.expired_owner = out_owner_q;
	assign rsp.expired_event = out_event_q;
	assign rsp.removed_count = out_removed_q;
	assign rsp.next_wait     = out_wait_q;
	assign rsp.any_pending   = out_pend_q;
	assign rsp.last          = out_last_q;

endmodule

`default_nettype wire

// ===== sv/multi_slot_software_timer_table.sv =====
// Table of SLOT_COUNT one-shot timers. A start request stores a timer in the lowest free
// slot (status full when none is free); a stop request frees the slots that match the
// owner, or owner and event; a tick request expires every slot whose elapsed time modulo
// 2^TICK_BITS reaches its interval and returns one expired result per slot, highest slot
// first. Every request closes with one summary result (last set) carrying the least
// remaining time over the live slots and a pending flag. A request is captured and stored,
// then its slots are scanned, one slot read a cycle while the result side does not stall,
// from the single read port of the slot ram; then the last slot is finished and the summary
// issued. A stalled expired result holds the scan. Live bits are flip-flops cleared at
// reset, so no clearing pass follows reset; the next request is taken while the summary
// still waits in the result register.
`default_nettype none

module multi_slot_software_timer_table #(
	parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
	parameter int TICK_BITS  = mstt_pkg::TICK_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mstt_req_if.sink   req,
	mstt_rsp_if.source rsp
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	mstt_pkg::ctl_cmd_t cmd;
	mstt_pkg::dp_stat_t stat;
	logic [IDX_W-1:0]   rd_idx;
	logic               in_ready;

	assign req.ready = in_ready;

	mstt_ctrl #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd),
		.rd_idx   (rd_idx)
	);

	mstt_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.TICK_BITS  (TICK_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_idx     (rd_idx),
		.stat       (stat),
		.req_type   (req.req_type),
		.owner_id   (req.owner_id),
		.event_kind (req.event_kind),
		.wait_ticks (req.wait_ticks),
		.now_tick   (req.now_tick),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/sv/multi_slot_software_timer_table_tb.sv =====
// self-checking testbench of the software timer table: slot table predictor, scoreboard and drivers
`default_nettype none

import mstt_pkg::*;

typedef struct packed {
	status_t              status;
	logic [OWNER_W-1:0]   expired_owner;
	logic [EVENT_W-1:0]   expired_event;
	logic [REMOVED_W-1:0] removed_count;
	logic [WAIT_W-1:0]    next_wait;
	logic                 any_pending;
	logic                 last;
} timer_result_t;

class timer_table_scoreboard;
	bit                 live [SLOT_COUNT_DEF];
	logic [OWNER_W-1:0] owner [SLOT_COUNT_DEF];
	logic [EVENT_W-1:0] kind [SLOT_COUNT_DEF];
	logic [WAIT_W-1:0]  interval [SLOT_COUNT_DEF];
	logic [NOW_W-1:0]   start [SLOT_COUNT_DEF];
	timer_result_t      expected_results [$];
	int                 errors;
	int                 req_count [4];
	int                 full_count;
	int                 expired_count;
	int                 checked_count;

	function new();
		errors = 0;
		full_count = 0;
		expired_count = 0;
		checked_count = 0;
		foreach (live[s]) live[s] = 1'b0;
		foreach (req_count[i]) req_count[i] = 0;
	endfunction

	function logic [WAIT_W-1:0] ticks_left(int s, logic [NOW_W-1:0] now);
		logic [NOW_W-1:0] elapsed;
		elapsed = now - start[s];
		if (elapsed >= {1'b0, interval[s]})
			return '0;
		return interval[s] - elapsed[WAIT_W-1:0];
	endfunction

	function void push_summary(status_t st, logic [REMOVED_W-1:0] removed,
		logic [NOW_W-1:0] now);
		timer_result_t r;
		logic [WAIT_W-1:0] left;
		r = '0;
		r.status = st;
		r.removed_count = removed;
		r.next_wait = NO_WAIT;
		r.last = 1'b1;
		for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
			if (live[s]) begin
				left = ticks_left(s, now);
				r.any_pending = 1'b1;
				if (left < r.next_wait)
					r.next_wait = left;
			end
		end
		expected_results.push_back(r);
	endfunction

	function void note_request(req_code_t code, logic [OWNER_W-1:0] own, logic [EVENT_W-1:0] ev,
		logic [WAIT_W-1:0] ivl, logic [NOW_W-1:0] now);
		int free_slot;
		logic [REMOVED_W-1:0] removed;
		timer_result_t r;
		req_count[code]++;
		case (code)
			REQ_START: begin
				free_slot = -1;
				for (int s = 0; s < SLOT_COUNT_DEF; s++)
					if (!live[s] && free_slot < 0)
						free_slot = s;
				if (free_slot >= 0) begin
					live[free_slot] = 1'b1;
					owner[free_slot] = own;
					kind[free_slot] = ev;
					interval[free_slot] = ivl;
					start[free_slot] = now;
					push_summary(ST_START_OK, '0, now);
				end else begin
					full_count++;
					push_summary(ST_FULL, '0, now);
				end
			end
			REQ_STOP_OWNER, REQ_STOP_EVENT: begin
				removed = '0;
				for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
					if (live[s] && owner[s] == own &&
						(code == REQ_STOP_OWNER || kind[s] == ev)) begin
						live[s] = 1'b0;
						if (removed != REMOVED_MAX)
							removed++;
					end
				end
				push_summary(ST_DONE, removed, now);
			end
			default: begin
				// highest slot expires first
				for (int s = SLOT_COUNT_DEF - 1; s >= 0; s--) begin
					if (live[s] && ticks_left(s, now) == '0) begin
						live[s] = 1'b0;
						r = '0;
						r.status = ST_EXPIRED;
						r.expired_owner = owner[s];
						r.expired_event = kind[s];
						expected_results.push_back(r);
						expired_count++;
					end
				end
				push_summary(ST_DONE, '0, now);
			end
		endcase
	endfunction

	function void compare_field(string name, logic [NOW_W-1:0] exp_v, logic [NOW_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(timer_result_t act);
		timer_result_t exp_r;
		checked_count++;
		if (expected_results.size() == 0) begin
			$error("unexpected result with status %0d", act.status);
			errors++;
			return;
		end
		exp_r = expected_results.pop_front();
		compare_field("status", NOW_W'(exp_r.status), NOW_W'(act.status));
		compare_field("expired_owner", NOW_W'(exp_r.expired_owner),
			NOW_W'(act.expired_owner));
		compare_field("expired_event", NOW_W'(exp_r.expired_event),
			NOW_W'(act.expired_event));
		compare_field("removed_count", NOW_W'(exp_r.removed_count),
			NOW_W'(act.removed_count));
		compare_field("next_wait", NOW_W'(exp_r.next_wait), NOW_W'(act.next_wait));
		compare_field("any_pending", NOW_W'(exp_r.any_pending), NOW_W'(act.any_pending));
		compare_field("last", NOW_W'(exp_r.last), NOW_W'(act.last));
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module multi_slot_software_timer_table_tb;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 420;
	localparam int QUIET_ITEMS  = 60;

	logic                  clk;
	logic                  arst_n;
	bit                    quiet;
	int                    cycle_count;
	logic [NOW_W-1:0]      clock_now;
	timer_table_scoreboard sb;

	mstt_req_if req ();
	mstt_rsp_if rsp ();

	multi_slot_software_timer_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_result({rsp.status, rsp.expired_owner, rsp.expired_event,
				rsp.removed_count, rsp.next_wait, rsp.any_pending, rsp.last});
	end

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(req_code_t code, logic [OWNER_W-1:0] own,
		logic [EVENT_W-1:0] ev, logic [WAIT_W-1:0] ivl, logic [NOW_W-1:0] now);
		req.valid <= 1'b1;
		req.req_type <= code;
		req.owner_id <= own;
		req.event_kind <= ev;
		req.wait_ticks <= ivl;
		req.now_tick <= now;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(code, own, ev, ivl, now);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		req.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		logic [NOW_W-1:0] base;
		base = 32'hffff_fff0;
		send_request(REQ_TICK, 8'h00, 8'h00, '0, base);
		send_request(REQ_START, 8'hff, 8'h00, '0, base);
		send_request(REQ_START, 8'h00, 8'hff, NO_WAIT, base);
		// tick counter wraps past zero here
		send_request(REQ_TICK, 8'hff, 8'hff, NO_WAIT, base + 32'h20);
		for (int i = 0; i < 15; i++)
			send_request(REQ_START, 8'(i % 3 + 1), 8'(i % 2), 31'(16 + i), base + 32'h20);
		send_request(REQ_START, 8'h12, 8'h34, 31'd5, base + 32'h20);
		// every slot expires at once
		send_request(REQ_TICK, 8'h00, 8'h00, '0, base + 32'h8000_0020);
		send_request(REQ_START, 8'h07, 8'h01, 31'd50, base + 32'h100);
		send_request(REQ_START, 8'h07, 8'h02, 31'd60, base + 32'h101);
		send_request(REQ_START, 8'h07, 8'h01, 31'd70, base + 32'h102);
		send_request(REQ_STOP_EVENT, 8'h07, 8'h01, '0, base + 32'h103);
		send_request(REQ_STOP_OWNER, 8'h07, 8'h00, '0, base + 32'h104);
		send_request(REQ_STOP_OWNER, 8'h55, 8'haa, '0, base + 32'h105);
	endtask

	task automatic send_random();
		int pick;
		req_code_t code;
		logic [OWNER_W-1:0] own;
		logic [EVENT_W-1:0] ev;
		logic [WAIT_W-1:0] ivl;
		logic [NOW_W-1:0] now;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			code = REQ_START;
		else if (pick < 55)
			code = REQ_STOP_OWNER;
		else if (pick < 65)
			code = REQ_STOP_EVENT;
		else
			code = REQ_TICK;
		own = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
		ev = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		ivl = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 300));
		// mostly a steadily advancing tick, sometimes an arbitrary one
		if ($urandom_range(0, 19) == 0) begin
			now = $urandom;
		end else begin
			clock_now = clock_now + $urandom_range(0, 40);
			now = clock_now;
		end
		send_request(code, own, ev, ivl, now);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		quiet = 1'b0;
		cycle_count = 0;
		clock_now = $urandom;
		req.valid = 1'b0;
		req.req_type = REQ_START;
		req.owner_id = '0;
		req.event_kind = '0;
		req.wait_ticks = '0;
		req.now_tick = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
			send_random();
			if (i == RANDOM_ITEMS / 2)
				hold_until_drained();
		end
		req.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("requests: %0d start, %0d full, %0d stop owner, %0d stop event, %0d tick",
			sb.req_count[REQ_START], sb.full_count, sb.req_count[REQ_STOP_OWNER],
			sb.req_count[REQ_STOP_EVENT], sb.req_count[REQ_TICK]);
		$display("results checked: %0d, timer expiries among them: %0d, mismatches: %0d",
			sb.checked_count, sb.expired_count, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/mstt_pkg.sv
sv/mstt_req_if.sv
sv/mstt_rsp_if.sv
sv/mstt_ram.sv
sv/mstt_ctrl.sv
sv/mstt_dp.sv
sv/multi_slot_software_timer_table.sv
tb/sv/multi_slot_software_timer_table_tb.sv
